/* hdl/pls_pkg.sv */
// Shared types and constants for the positional list store.
// Holds the request/result words, mode and status codes, and the
// command/flag structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package pls_pkg;

	localparam int DEPTH      = 16;
	localparam int ITEM_WIDTH = 32;
	localparam int MODE_W     = 4;
	localparam int POS_W      = 5;
	localparam int STAT_W     = 3;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int IDX_W      = $clog2(DEPTH);

	localparam logic [MODE_W-1:0] MODE_READ       = 4'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE      = 4'd1;
	localparam logic [MODE_W-1:0] MODE_INS_FRONT  = 4'd2;
	localparam logic [MODE_W-1:0] MODE_INS_END    = 4'd3;
	localparam logic [MODE_W-1:0] MODE_INS_AT     = 4'd4;
	localparam logic [MODE_W-1:0] MODE_REM_FRONT  = 4'd5;
	localparam logic [MODE_W-1:0] MODE_REM_END    = 4'd6;
	localparam logic [MODE_W-1:0] MODE_REM_AT     = 4'd7;
	localparam logic [MODE_W-1:0] MODE_SEARCH     = 4'd8;
	localparam logic [MODE_W-1:0] MODE_CLEAR      = 4'd9;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic [MODE_W-1:0]     mode;
		logic [POS_W-1:0]      position;
		logic [ITEM_WIDTH-1:0] item;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]     status;
		logic [ITEM_WIDTH-1:0] item_out;
		logic [CNT_W-1:0]      count;
	} rsp_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_READ,
		OP_WRITE,
		OP_INSERT,
		OP_REMOVE,
		OP_FOUND,
		OP_CLEAR
	} op_t;

	typedef enum logic [1:0] {
		AT_FRONT,
		AT_END,
		AT_POS
	} at_sel_t;

	typedef struct packed {
		logic              capture;
		logic              exec;
		op_t               op;
		at_sel_t           at_sel;
		logic [STAT_W-1:0] status;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              pos_ok;
		logic              empty;
		logic              full;
		logic              found;
	} flags_t;

endpackage

/* hdl/positional_list_store.sv */
// Top level of the positional list store: bounded ordered list addressed by
// 1-based position. Instantiates pls_ctrl and pls_dp; depends on pls_pkg.
//
//   channel   handshake                words               direction
//   request   start / busy             mode, position, item  in
//   result    done (one-cycle strobe)  status, item_out, count out
//
// A request is latched at the accepting edge; in the next cycle, the
// execute state, it is decoded, all cells are compared against the key
// and the cell row shifts in parallel. No new request is taken during
// execute. The result sits on result for the cycle after execute,
// flagged by done, while busy is already low again. Reset clears the count
// and the sequencer only; cell contents are left as they are. The receiver
// cannot stall: each result is valid for exactly one cycle.
`timescale 1ns / 1ps

module positional_list_store (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pls_pkg::req_t request,
	output logic          done,
	output pls_pkg::rsp_t result
);

	pls_pkg::cmd_t   cmd;
	pls_pkg::flags_t flags;

	pls_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.flags  (flags),
		.cmd    (cmd)
	);

	pls_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.flags   (flags),
		.result  (result)
	);

endmodule

/* hdl/pls_ctrl.sv */
// Controller for the positional list store: two-state sequencer and
// request decode into datapath commands. Depends on pls_pkg.
`timescale 1ns / 1ps

module pls_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	input  pls_pkg::flags_t flags,
	output pls_pkg::cmd_t   cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_EXEC);
		end
	end

	assign busy = (state_q == ST_EXEC);
	assign done = done_q;

	// Decode the latched request against the current list state.
	always_comb begin
		cmd         = '0;
		cmd.op      = pls_pkg::OP_NONE;
		cmd.at_sel  = pls_pkg::AT_POS;
		cmd.status  = pls_pkg::ST_OK;
		cmd.capture = start && (state_q == ST_IDLE);
		cmd.exec    = (state_q == ST_EXEC);
		case (flags.mode)
			pls_pkg::MODE_READ: begin
				if (!flags.pos_ok)
					cmd.status = pls_pkg::ST_BADPOS;
				else
					cmd.op = pls_pkg::OP_READ;
			end
			pls_pkg::MODE_WRITE: begin
				if (!flags.pos_ok)
					cmd.status = pls_pkg::ST_BADPOS;
				else
					cmd.op = pls_pkg::OP_WRITE;
			end
			pls_pkg::MODE_INS_FRONT, pls_pkg::MODE_INS_END, pls_pkg::MODE_INS_AT: begin
				if (flags.mode == pls_pkg::MODE_INS_FRONT)
					cmd.at_sel = pls_pkg::AT_FRONT;
				else if (flags.mode == pls_pkg::MODE_INS_END)
					cmd.at_sel = pls_pkg::AT_END;
				if (flags.mode == pls_pkg::MODE_INS_AT && !flags.pos_ok)
					cmd.status = pls_pkg::ST_BADPOS;
				else if (flags.full)
					cmd.status = pls_pkg::ST_FULL;
				else
					cmd.op = pls_pkg::OP_INSERT;
			end
			pls_pkg::MODE_REM_FRONT, pls_pkg::MODE_REM_END, pls_pkg::MODE_REM_AT: begin
				if (flags.mode == pls_pkg::MODE_REM_FRONT)
					cmd.at_sel = pls_pkg::AT_FRONT;
				else if (flags.mode == pls_pkg::MODE_REM_END)
					cmd.at_sel = pls_pkg::AT_END;
				// empty list wins over a bad position
				if (flags.empty)
					cmd.status = pls_pkg::ST_EMPTY;
				else if (flags.mode == pls_pkg::MODE_REM_AT && !flags.pos_ok)
					cmd.status = pls_pkg::ST_BADPOS;
				else
					cmd.op = pls_pkg::OP_REMOVE;
			end
			pls_pkg::MODE_SEARCH: begin
				if (flags.empty)
					cmd.status = pls_pkg::ST_EMPTY;
				else if (flags.found)
					cmd.op = pls_pkg::OP_FOUND;
				else
					cmd.status = pls_pkg::ST_NOTFOUND;
			end
			pls_pkg::MODE_CLEAR: begin
				cmd.op = pls_pkg::OP_CLEAR;
			end
			default: begin
				cmd.op = pls_pkg::OP_NONE;
			end
		endcase
		// outside the execute cycle nothing may touch the list
		if (state_q != ST_EXEC) begin
			cmd.op     = pls_pkg::OP_NONE;
			cmd.status = pls_pkg::ST_OK;
		end
	end

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_EXEC))
		else $error("result strobe without an execute cycle");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not start execution");

	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (!busy && done))
		else $error("execute cycle not followed by a result");

endmodule

/* hdl/pls_dp.sv */
// Datapath for the positional list store: request register, cell row with
// per-cell shift, parallel search compare, count and result register.
// Depends on pls_pkg.
`timescale 1ns / 1ps

module pls_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  pls_pkg::req_t   request,
	input  pls_pkg::cmd_t   cmd,
	output pls_pkg::flags_t flags,
	output pls_pkg::rsp_t   result
);

	localparam int N   = pls_pkg::DEPTH;
	localparam int IW  = pls_pkg::ITEM_WIDTH;
	localparam int CW  = pls_pkg::CNT_W;
	localparam int XW  = pls_pkg::IDX_W;
	localparam int PW  = pls_pkg::POS_W;

	pls_pkg::req_t req_q;
	pls_pkg::rsp_t result_q;
	logic [CW-1:0] count_q, count_d;
	logic [IW-1:0] cells_q [N];
	logic [IW-1:0] cells_d [N];
	logic [IW-1:0] shift_up [N];
	logic [IW-1:0] shift_dn [N];
	logic [N-1:0]  match;
	logic [XW-1:0] idx, last, tail, at;
	logic [IW-1:0] rd_item;

	always_ff @(posedge clk) begin
		if (cmd.capture)
			req_q <= request;
	end

	assign idx  = XW'(req_q.position - PW'(1));
	assign last = XW'(count_q - CW'(1));
	assign tail = XW'(count_q);

	always_comb begin
		case (cmd.at_sel)
			pls_pkg::AT_FRONT: at = '0;
			pls_pkg::AT_END:   at = (cmd.op == pls_pkg::OP_INSERT) ? tail : last;
			pls_pkg::AT_POS:   at = idx;
			default:           at = '0;
		endcase
	end

	assign rd_item = cells_q[at];

	// Compare every live cell against the key at once.
	always_comb begin
		for (int i = 0; i < N; i++)
			match[i] = (cells_q[i] == req_q.item) && (CW'(i) < count_q);
	end

	always_comb begin
		flags.mode   = req_q.mode;
		flags.pos_ok = (req_q.position != '0) && (req_q.position <= PW'(count_q));
		flags.empty  = (count_q == '0);
		flags.full   = (count_q == CW'(N));
		flags.found  = |match;
	end

	always_comb begin
		shift_up[0] = cells_q[0];
		for (int i = 1; i < N; i++)
			shift_up[i] = cells_q[i-1];
		shift_dn[N-1] = cells_q[N-1];
		for (int i = 0; i < N - 1; i++)
			shift_dn[i] = cells_q[i+1];
	end

	// Write the target cell, or open or close the gap at it; cells above count are don't-care.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			cells_d[i] = cells_q[i];
			case (cmd.op)
				pls_pkg::OP_WRITE: begin
					if (XW'(i) == at)
						cells_d[i] = req_q.item;
				end
				pls_pkg::OP_INSERT: begin
					if (XW'(i) == at)
						cells_d[i] = req_q.item;
					else if (XW'(i) > at)
						cells_d[i] = shift_up[i];
				end
				pls_pkg::OP_REMOVE: begin
					if (XW'(i) >= at)
						cells_d[i] = shift_dn[i];
				end
				default: begin
					cells_d[i] = cells_q[i];
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++)
			cells_q[i] <= cells_d[i];
	end

	always_comb begin
		case (cmd.op)
			pls_pkg::OP_INSERT: count_d = count_q + CW'(1);
			pls_pkg::OP_REMOVE: count_d = count_q - CW'(1);
			pls_pkg::OP_CLEAR:  count_d = '0;
			default:            count_d = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else
			count_q <= count_d;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			result_q.status <= cmd.status;
			result_q.count  <= count_d;
			case (cmd.op)
				pls_pkg::OP_READ, pls_pkg::OP_REMOVE: result_q.item_out <= rd_item;
				pls_pkg::OP_FOUND:                    result_q.item_out <= req_q.item;
				default:                              result_q.item_out <= '0;
			endcase
		end
	end

	assign result = result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(N))
		else $error("item count beyond store depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == pls_pkg::OP_INSERT) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not advance count");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == pls_pkg::OP_REMOVE) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("remove did not drop count");

endmodule
